FILE: sv/cpfq_pkg.sv
// Shared types and constants for the CAN priority frame queue.
`timescale 1ns / 1ps

package cpfq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam int ID_W                = 11;
    localparam int LEN_W               = 4;
    localparam int DATA_W              = 64;
    localparam int LEVEL_W             = 5;
    localparam int RCOUNT_W            = 4;

    localparam logic [RCOUNT_W-1:0] READER_COUNT_RESET = 4'd3;

    localparam logic OP_SEND    = 1'b0;
    localparam logic OP_RECEIVE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_len;
        logic [DATA_W-1:0] frame_data;
    } frame_req_t;

    typedef struct packed {
        logic               send_accepted;
        logic               frame_valid;
        logic [ID_W-1:0]    out_id;
        logic [LEN_W-1:0]   out_len;
        logic [DATA_W-1:0]  out_data;
        logic               frame_cleared;
        logic [LEVEL_W-1:0] queue_level;
    } frame_rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } entry_t;

endpackage

FILE: sv/can_priority_frame_queue.sv
// CAN frame store that serves the lowest identifier first, oldest first among equals.
`timescale 1ns / 1ps

// A send transfer appends a frame at the tail of a store with one write port and one
// registered read port (dropped and flagged when full). A receive transfer scans the
// held entries one per cycle through the store's registered read port, keeping the
// lowest identifier seen so far; on the last permitted read the winning entry is
// removed by moving each later entry down one slot, again one per cycle. A receive
// on an empty store skips the scan and answers with no valid frame. The request
// channel is held off while an item is in progress; a finished result waits in an
// output register so the next item can be taken before it is collected. The reader
// count may be written at any time the block is idle and takes effect on the next
// receive.
module can_priority_frame_queue
    import cpfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  frame_req_t          req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output frame_rsp_t          rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RCOUNT_W-1:0] cfg_reader_count
);

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    entry_t entry_mem [QUEUE_DEPTH];

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [RCOUNT_W-1:0] reads_done_reg, reads_done_next;
    logic [RCOUNT_W-1:0] reader_count_reg;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    entry_t              best_reg, best_next;
    entry_t              rd_data_reg;
    frame_rsp_t          res_reg, res_next;
    frame_rsp_t          rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    entry_t              mem_wd;
    logic [ADDR_W-1:0]   rd_addr;

    logic                take_cur;
    entry_t              best_cur;
    logic [ADDR_W-1:0]   best_idx_cur;
    logic [CNT_W-1:0]    idx_inc, idx_inc2, best_inc;
    logic [RCOUNT_W-1:0] read_cnt, limit;

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The entry read last cycle belongs to idx_reg; the first one seeds the minimum.
    assign take_cur     = (idx_reg == '0) || (rd_data_reg.id < best_reg.id);
    assign best_cur     = take_cur ? rd_data_reg : best_reg;
    assign best_idx_cur = take_cur ? idx_reg : best_idx_reg;

    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_inc2 = CNT_W'(idx_reg) + CNT_W'(2);
    assign best_inc = CNT_W'(best_idx_cur) + CNT_W'(1);
    assign read_cnt = reads_done_reg + RCOUNT_W'(1);
    assign limit    = (reader_count_reg == '0) ? RCOUNT_W'(1) : reader_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        reads_done_next = reads_done_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        mem_we          = 1'b0;
        mem_wa          = idx_reg;
        mem_wd          = '{id: req.frame_id, len: req.frame_len, data: req.frame_data};
        rd_addr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_next = '0;
                    if (req.opcode == OP_SEND)
                    begin
                        if (held_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            mem_we                 = 1'b1;
                            mem_wa                 = held_reg[ADDR_W-1:0];
                            held_next              = held_reg + CNT_W'(1);
                            reads_done_next        = '0;
                            res_next.send_accepted = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else if (held_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                best_next     = best_cur;
                best_idx_next = best_idx_cur;
                if (idx_inc == held_reg)
                begin
                    res_next.frame_valid = 1'b1;
                    res_next.out_id      = best_cur.id;
                    res_next.out_len     = best_cur.len;
                    res_next.out_data    = best_cur.data;
                    if (read_cnt >= limit)
                    begin
                        res_next.frame_cleared = 1'b1;
                        reads_done_next        = '0;
                        if (best_inc < held_reg)
                        begin
                            rd_addr    = best_inc[ADDR_W-1:0];
                            idx_next   = best_idx_cur;
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            held_next  = held_reg - CNT_W'(1);
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        reads_done_next = read_cnt;
                        state_next      = ST_DONE;
                    end
                end
                else
                begin
                    rd_addr  = idx_inc[ADDR_W-1:0];
                    idx_next = idx_inc[ADDR_W-1:0];
                end
            end

            ST_SHIFT:
            begin
                // The entry above idx_reg has just been read; move it down one slot.
                mem_we = 1'b1;
                mem_wa = idx_reg;
                mem_wd = rd_data_reg;
                if (idx_inc2 < held_reg)
                begin
                    rd_addr  = idx_inc2[ADDR_W-1:0];
                    idx_next = idx_inc[ADDR_W-1:0];
                end
                else
                begin
                    held_next  = held_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next             = res_reg;
                    rsp_next.queue_level = LEVEL_W'(held_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        idx_reg      <= idx_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            held_reg         <= '0;
            reads_done_reg   <= '0;
            reader_count_reg <= READER_COUNT_RESET;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            reads_done_reg <= reads_done_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                reader_count_reg <= cfg_reader_count;
            end
        end
    end

endmodule
